// ===== hw/rtl/cdcrs_pkg.sv =====
// ============================================================================
// cdcrs_pkg: shared types and constants of the dual-copy record store
// Request and response payloads, operation and status codes, and the range
// check on the placement of a record's two copies.
// ============================================================================
package cdcrs_pkg;

    localparam int STORE_WORDS      = 128;
    localparam int MAX_RECORD_WORDS = 63;

    localparam int WORD_W  = 32;
    localparam int INDEX_W = 7;
    localparam int COUNT_W = 6;
    localparam int ADDR_W  = $clog2(STORE_WORDS);
    localparam int CHK_W   = $clog2(STORE_WORDS + 256) + 1;

    localparam logic [1:0] OP_STORE    = 2'd0;
    localparam logic [1:0] OP_RETRIEVE = 2'd1;
    localparam logic [1:0] OP_CLEAR    = 2'd2;

    localparam logic [1:0] ST_PRIMARY   = 2'd0;
    localparam logic [1:0] ST_SECONDARY = 2'd1;
    localparam logic [1:0] ST_NO_VALID  = 2'd2;
    localparam logic [1:0] ST_RANGE     = 2'd3;

    typedef struct packed {
        logic [1:0]         op;
        logic [INDEX_W-1:0] index;
        logic [COUNT_W-1:0] count;
        logic [WORD_W-1:0]  data;
        logic               last;
    } req_t;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic [1:0]        status;
        logic              final_res;
    } rsp_t;

    function automatic logic out_of_range(logic [INDEX_W-1:0] idx, logic [COUNT_W-1:0] n);
        logic [CHK_W-1:0] span;
        span = CHK_W'(idx) + ((CHK_W'(n) + CHK_W'(1)) << 1);
        return (n == '0) || (32'(n) > 32'(MAX_RECORD_WORDS)) ||
               (span > CHK_W'(STORE_WORDS));
    endfunction

endpackage

// ===== hw/rtl/checksummed_dual_copy_record_store.sv =====
// ============================================================================
// checksummed_dual_copy_record_store: word store with two checked copies
// Stores records as a primary and a secondary copy, each closed by an
// inverted XOR check word, and returns the first copy that checks as valid.
// ============================================================================
// One request is worked on at a time, and the request side stalls until the
// sequencer is idle again; a finished response waits in the output register
// while the next request is taken. All sequencing follows from the single
// read port of the word memory, whose read data is registered. A store
// request that starts a record walks the primary copy first, then writes
// its word; each further store word is written on its own, and the closing
// word is followed by the check word and the response. A retrieve walks
// each copy that it checks, then reads and returns one word at a time
// while the response side is not stalled. A clear needs no pass over the
// memory: each memory word has a valid bit, and a word that is not valid
// reads as zero, so no clearing pass is needed after reset or clear.
module checksummed_dual_copy_record_store (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_stall,
    input  cdcrs_pkg::req_t req,
    output logic            rsp_valid,
    input  logic            rsp_stall,
    output cdcrs_pkg::rsp_t rsp
);
    import cdcrs_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_WR_DATA,
        S_WR_CHK,
        S_RD_ISSUE,
        S_RD_EMIT,
        S_EMIT
    } state_t;

    state_t             state_reg;
    logic               mode_store_reg;
    logic               second_reg;
    logic [INDEX_W-1:0] idx_reg;
    logic [COUNT_W-1:0] cnt_reg;
    logic [WORD_W-1:0]  data_reg;
    logic               last_reg;
    logic [ADDR_W-1:0]  wp_reg;
    logic [WORD_W-1:0]  rc_reg;
    logic               active_reg;
    logic               chosen_reg;
    logic [COUNT_W-1:0] wl_reg;
    logic [ADDR_W-1:0]  chk_base_reg;
    logic [COUNT_W-1:0] iss_reg;
    logic               iss_done_reg;
    logic               pend_reg;
    logic               pend_last_reg;
    logic [WORD_W-1:0]  acc_reg;
    logic [1:0]         em_status_reg;
    logic [ADDR_W-1:0]  rd_base_reg;
    logic [COUNT_W-1:0] rd_i_reg;
    logic [1:0]         rd_status_reg;
    logic               rsp_valid_reg;
    rsp_t               rsp_reg;

    logic [STORE_WORDS-1:0] valid_reg;
    logic [WORD_W-1:0]      mem [STORE_WORDS];
    logic [WORD_W-1:0]      rd_data_reg;
    logic                   rd_bit_reg;

    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [WORD_W-1:0]  wr_data;
    logic               rd_en;
    logic [ADDR_W-1:0]  rd_addr;
    logic [WORD_W-1:0]  rd_word;
    logic [ADDR_W-1:0]  sec_base;
    logic               accept;
    logic               out_free;
    logic               emit;
    logic               copy_ok;
    logic               req_oor;

    assign req_stall = (state_reg != S_IDLE);
    assign accept    = req_valid && !req_stall;
    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign emit      = out_free && ((state_reg == S_RD_EMIT) || (state_reg == S_EMIT));
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign req_oor  = out_of_range(req.index, req.count);
    assign sec_base = ADDR_W'(CHK_W'(idx_reg) + CHK_W'(cnt_reg) + CHK_W'(1));
    assign rd_word  = rd_bit_reg ? rd_data_reg : '0;
    assign copy_ok  = (~acc_reg == rd_word);

    assign wr_en   = (state_reg == S_WR_DATA) || (state_reg == S_WR_CHK);
    assign wr_addr = wp_reg;
    assign wr_data = (state_reg == S_WR_DATA) ? data_reg : ~rc_reg;
    assign rd_en   = ((state_reg == S_CHECK) && !iss_done_reg) || (state_reg == S_RD_ISSUE);
    assign rd_addr = (state_reg == S_CHECK) ?
                     ADDR_W'(chk_base_reg + ADDR_W'(iss_reg)) :
                     ADDR_W'(rd_base_reg + ADDR_W'(rd_i_reg));

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
            rd_bit_reg  <= valid_reg[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            mode_store_reg <= 1'b0;
            second_reg     <= 1'b0;
            wp_reg         <= '0;
            rc_reg         <= '0;
            active_reg     <= 1'b0;
            chosen_reg     <= 1'b0;
            wl_reg         <= '0;
            iss_reg        <= '0;
            iss_done_reg   <= 1'b0;
            pend_reg       <= 1'b0;
            pend_last_reg  <= 1'b0;
            rd_i_reg       <= '0;
            rsp_valid_reg  <= 1'b0;
            valid_reg      <= '0;
        end
        else
        begin
            if (rsp_valid_reg && !rsp_stall && !emit)
            begin
                rsp_valid_reg <= 1'b0;
            end
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        case (req.op)
                            OP_STORE:
                            begin
                                data_reg <= req.data;
                                last_reg <= req.last;
                                if (active_reg)
                                begin
                                    state_reg <= S_WR_DATA;
                                end
                                else if (req_oor)
                                begin
                                    em_status_reg <= ST_RANGE;
                                    state_reg     <= S_EMIT;
                                end
                                else
                                begin
                                    idx_reg        <= req.index;
                                    cnt_reg        <= req.count;
                                    mode_store_reg <= 1'b1;
                                    second_reg     <= 1'b0;
                                    chk_base_reg   <= ADDR_W'(req.index);
                                    iss_reg        <= '0;
                                    iss_done_reg   <= 1'b0;
                                    pend_reg       <= 1'b0;
                                    acc_reg        <= '0;
                                    state_reg      <= S_CHECK;
                                end
                            end
                            OP_RETRIEVE:
                            begin
                                active_reg <= 1'b0;
                                wl_reg     <= '0;
                                if (req_oor)
                                begin
                                    em_status_reg <= ST_RANGE;
                                    state_reg     <= S_EMIT;
                                end
                                else
                                begin
                                    idx_reg        <= req.index;
                                    cnt_reg        <= req.count;
                                    mode_store_reg <= 1'b0;
                                    second_reg     <= 1'b0;
                                    chk_base_reg   <= ADDR_W'(req.index);
                                    iss_reg        <= '0;
                                    iss_done_reg   <= 1'b0;
                                    pend_reg       <= 1'b0;
                                    acc_reg        <= '0;
                                    state_reg      <= S_CHECK;
                                end
                            end
                            OP_CLEAR:
                            begin
                                valid_reg  <= '0;
                                wp_reg     <= '0;
                                rc_reg     <= '0;
                                active_reg <= 1'b0;
                                chosen_reg <= 1'b0;
                                wl_reg     <= '0;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end

                S_CHECK:
                begin
                    if (!iss_done_reg)
                    begin
                        pend_reg      <= 1'b1;
                        pend_last_reg <= (iss_reg == cnt_reg);
                        if (iss_reg == cnt_reg)
                        begin
                            iss_done_reg <= 1'b1;
                        end
                        else
                        begin
                            iss_reg <= iss_reg + COUNT_W'(1);
                        end
                    end
                    else
                    begin
                        pend_reg <= 1'b0;
                    end

                    if (pend_reg && !pend_last_reg)
                    begin
                        acc_reg <= acc_reg ^ rd_word;
                    end
                    else if (pend_reg)
                    begin
                        if (mode_store_reg)
                        begin
                            chosen_reg <= copy_ok;
                            wp_reg     <= copy_ok ? sec_base : ADDR_W'(idx_reg);
                            rc_reg     <= '0;
                            wl_reg     <= cnt_reg;
                            active_reg <= 1'b1;
                            state_reg  <= S_WR_DATA;
                        end
                        else if (copy_ok)
                        begin
                            rd_base_reg   <= chk_base_reg;
                            rd_i_reg      <= '0;
                            rd_status_reg <= second_reg ? ST_SECONDARY : ST_PRIMARY;
                            state_reg     <= S_RD_ISSUE;
                        end
                        else if (!second_reg)
                        begin
                            second_reg   <= 1'b1;
                            chk_base_reg <= sec_base;
                            iss_reg      <= '0;
                            iss_done_reg <= 1'b0;
                            acc_reg      <= '0;
                        end
                        else
                        begin
                            em_status_reg <= ST_NO_VALID;
                            state_reg     <= S_EMIT;
                        end
                    end
                end

                S_WR_DATA:
                begin
                    wp_reg <= wp_reg + ADDR_W'(1);
                    rc_reg <= rc_reg ^ data_reg;
                    wl_reg <= wl_reg - COUNT_W'(1);
                    if (last_reg || (wl_reg == COUNT_W'(1)))
                    begin
                        state_reg <= S_WR_CHK;
                    end
                    else
                    begin
                        state_reg <= S_IDLE;
                    end
                end

                S_WR_CHK:
                begin
                    active_reg    <= 1'b0;
                    wl_reg        <= '0;
                    em_status_reg <= chosen_reg ? ST_SECONDARY : ST_PRIMARY;
                    state_reg     <= S_EMIT;
                end

                S_RD_ISSUE:
                begin
                    state_reg <= S_RD_EMIT;
                end

                S_RD_EMIT:
                begin
                    if (out_free)
                    begin
                        rsp_valid_reg     <= 1'b1;
                        rsp_reg.word      <= rd_word;
                        rsp_reg.status    <= rd_status_reg;
                        rsp_reg.final_res <= (rd_i_reg == cnt_reg - COUNT_W'(1));
                        if (rd_i_reg == cnt_reg - COUNT_W'(1))
                        begin
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            rd_i_reg  <= rd_i_reg + COUNT_W'(1);
                            state_reg <= S_RD_ISSUE;
                        end
                    end
                end

                S_EMIT:
                begin
                    if (out_free)
                    begin
                        rsp_valid_reg     <= 1'b1;
                        rsp_reg.word      <= '0;
                        rsp_reg.status    <= em_status_reg;
                        rsp_reg.final_res <= 1'b1;
                        state_reg         <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== hw/rtl/cdcrs_checker.sv =====
// ============================================================================
// cdcrs_checker: port-level checks of the dual-copy record store
// Watches the request and response channels of the top level over time.
// ============================================================================
module cdcrs_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            req_valid,
    input logic            req_stall,
    input cdcrs_pkg::req_t req,
    input logic            rsp_valid,
    input logic            rsp_stall,
    input cdcrs_pkg::rsp_t rsp
);
    import cdcrs_pkg::*;

    // No response is offered while reset is held.
    a_no_rsp_in_reset: assert property (@(posedge clk) !rst_n |-> !rsp_valid)
        else $error("response valid during reset");

    // A stalled response stays offered and unchanged.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("stalled response changed");

    // A retrieve always occupies the block for at least the next cycle.
    a_retrieve_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall && (req.op == OP_RETRIEVE) |=> req_stall)
        else $error("retrieve request did not stall the request side");

    // Status-only responses carry a zero word and close their run.
    a_status_only: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && ((rsp.status == ST_NO_VALID) || (rsp.status == ST_RANGE))
        |-> (rsp.word == '0) && rsp.final_res)
        else $error("status-only response malformed");

    // Only data words of a retrieved copy may leave a run open.
    a_open_run: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.final_res
        |-> (rsp.status == ST_PRIMARY) || (rsp.status == ST_SECONDARY))
        else $error("open run with an error status");

endmodule

bind checksummed_dual_copy_record_store cdcrs_checker u_cdcrs_checker (.*);
